// ===== hw/rtl/dqsr_pkg.sv =====
`timescale 1ns / 1ps

package dqsr_pkg;

    // Field widths of the request and response
    localparam int KIND_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [KIND_W-1:0]          kind_t;
    typedef logic signed [DATA_W-1:0]   data_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [COUNT_W-1:0]         count_t;

    // Operation codes
    localparam kind_t KIND_PUSH_FRONT = 3'd0;
    localparam kind_t KIND_PUSH_BACK  = 3'd1;
    localparam kind_t KIND_POP_FRONT  = 3'd2;
    localparam kind_t KIND_POP_BACK   = 3'd3;
    localparam kind_t KIND_REPLACE    = 3'd4;

    // Status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_EMPTY     = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

endpackage

// ===== hw/rtl/dqsr_ifs.sv =====
`timescale 1ns / 1ps

// Request channel: one operation per request
interface dqsr_req_if import dqsr_pkg::*; ();
    logic  valid;
    logic  ready;
    kind_t kind;
    data_t value;
    data_t new_value;

    modport source (output valid, output kind, output value, output new_value, input ready);
    modport sink   (input valid, input kind, input value, input new_value, output ready);
endinterface

// Response channel: one result per request
interface dqsr_rsp_if import dqsr_pkg::*; ();
    logic    valid;
    logic    ready;
    status_t status;
    data_t   popped_value;
    count_t  entry_count;

    modport source (output valid, output status, output popped_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input popped_value, input entry_count,
                    output ready);
endinterface

// ===== hw/rtl/deque_with_search_replace.sv =====
`timescale 1ns / 1ps
// channel | dir | payload                          | handshake
// req     | in  | kind, value, new_value           | valid/ready
// rsp     | out | status, popped_value, entry_count | valid/ready
//
// One request at a time. Push: S_EXEC decides and writes the entry, S_FINISH hands over the
// result; pop: S_EXEC reads the entry memory, S_PICK takes the registered data, then S_FINISH.
// Replace scans the ring one entry per cycle through the single read port.
// Reset (rst_n, asynchronous) empties the deque; memory contents are not cleared.
// A finished result waits in a stage of its own; a stall on rsp holds it there
// and delays only the next result, not acceptance of the next request.

module deque_with_search_replace
    import dqsr_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    dqsr_req_if.sink     req,
    dqsr_rsp_if.source   rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam logic [CW:0]   CAP_EXT = (CW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PICK,
        S_SCAN,
        S_FINISH
    } state_t;

    // Entry memory with registered read
    logic [VALUE_BITS-1:0] mem [CAPACITY];
    logic [VALUE_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;

    state_t                state_reg, state_next;
    logic [AW-1:0]         front_reg, front_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         scan_idx_reg, scan_idx_next;
    kind_t                 op_kind_reg, op_kind_next;
    logic [VALUE_BITS-1:0] op_value_reg, op_value_next;
    logic [VALUE_BITS-1:0] op_new_reg, op_new_next;
    status_t               res_status_reg, res_status_next;
    data_t                 res_popped_reg, res_popped_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    status_t               out_status_reg, out_status_next;
    data_t                 out_popped_reg, out_popped_next;
    count_t                out_count_reg, out_count_next;

    logic [VALUE_BITS+DATA_W-1:0] val_ext;
    logic [VALUE_BITS+DATA_W-1:0] new_ext;
    logic [VALUE_BITS+DATA_W-1:0] rdata_ext;
    logic [CW+COUNT_W-1:0]        count_ext;
    logic [CW-1:0]                scan_nxt;
    logic                         is_full;
    logic                         is_empty;

    // Ring position of an offset from the front
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [CW-1:0] offset);
        logic [CW:0] sum;
        logic [CW:0] wrapped;
        sum     = {{(CW + 1 - AW){1'b0}}, front} + {1'b0, offset};
        wrapped = (sum >= CAP_EXT) ? sum - CAP_EXT : sum;
        return wrapped[AW-1:0];
    endfunction

    // Fit request values to the stored width and results to the port width
    assign val_ext   = {{VALUE_BITS{1'b0}}, req.value};
    assign new_ext   = {{VALUE_BITS{1'b0}}, req.new_value};
    assign rdata_ext = {{DATA_W{1'b0}}, rdata_reg};
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};
    assign scan_nxt  = scan_idx_reg + 1'b1;
    assign is_full   = (count_reg == CAP_CNT);
    assign is_empty  = (count_reg == '0);

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.popped_value = out_popped_reg;
    assign rsp.entry_count  = out_count_reg;

    // Sequence one request: decide, read, scan, hand over the result
    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        op_kind_next    = op_kind_reg;
        op_value_next   = op_value_reg;
        op_new_next     = op_new_reg;
        res_status_next = res_status_reg;
        res_popped_next = res_popped_reg;
        rsp_valid_next  = rsp_valid_reg;
        out_status_next = out_status_reg;
        out_popped_next = out_popped_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;

        // Drop a result once taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_kind_next  = req.kind;
                    op_value_next = val_ext[VALUE_BITS-1:0];
                    op_new_next   = new_ext[VALUE_BITS-1:0];
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = ST_OK;
                res_popped_next = '0;
                state_next      = S_FINISH;
                case (op_kind_reg)
                    KIND_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            front_next = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
                            mem_we     = 1'b1;
                            mem_waddr  = front_next;
                            mem_wdata  = op_value_reg;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    KIND_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = slot_of(front_reg, count_reg);
                            mem_wdata  = op_value_reg;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    KIND_POP_FRONT:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mem_raddr  = front_reg;
                            front_next = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            state_next = S_PICK;
                        end
                    end
                    KIND_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mem_raddr  = slot_of(front_reg, count_reg - 1'b1);
                            count_next = count_reg - 1'b1;
                            state_next = S_PICK;
                        end
                    end
                    KIND_REPLACE:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            mem_raddr     = front_reg;
                            scan_idx_next = '0;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end

            S_PICK:
            begin
                res_popped_next = rdata_ext[DATA_W-1:0];
                state_next      = S_FINISH;
            end

            S_SCAN:
            begin
                // Fetch the next entry while comparing this one
                mem_raddr = slot_of(front_reg, scan_nxt);
                if (rdata_reg == op_value_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = slot_of(front_reg, scan_idx_reg);
                    mem_wdata       = op_new_reg;
                    res_status_next = ST_OK;
                    state_next      = S_FINISH;
                end
                else if (scan_nxt == count_reg)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_FINISH;
                end
                else
                begin
                    scan_idx_next = scan_nxt;
                end
            end

            S_FINISH:
            begin
                // Hold the result until the output stage is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_popped_next = res_popped_reg;
                    out_count_next  = count_ext[COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            front_reg      <= '0;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            op_kind_reg    <= KIND_PUSH_FRONT;
            op_value_reg   <= '0;
            op_new_reg     <= '0;
            res_status_reg <= ST_OK;
            res_popped_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_popped_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            op_kind_reg    <= op_kind_next;
            op_value_reg   <= op_value_next;
            op_new_reg     <= op_new_next;
            res_status_reg <= res_status_next;
            res_popped_reg <= res_popped_next;
            rsp_valid_reg  <= rsp_valid_next;
            out_status_reg <= out_status_next;
            out_popped_reg <= out_popped_next;
            out_count_reg  <= out_count_next;
        end
    end

    // Write and read the entry memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Occupancy never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP_CNT)
        else $error("deque count above capacity");

    // Front pointer stays inside the ring
    assert property (@(posedge clk) disable iff (!rst_n) front_reg <= LAST_IDX)
        else $error("front pointer outside ring");

    // An accepted request goes straight to the decision step
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_EXEC)
        else $error("accepted request not executed");

    // An empty status always reports an empty deque
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && out_status_reg == ST_EMPTY |-> out_count_reg == '0)
        else $error("empty status with entries held");

endmodule

// ===== dv/deque_with_search_replace_test.sv =====
`timescale 1ns / 1ps

module deque_with_search_replace_test;
    import dqsr_pkg::*;

    localparam int    DEPTH        = 16;
    localparam int    WIDTH        = 32;
    localparam int    PERIOD       = 4;
    localparam int    RANDOM_ITEMS = 1530;
    localparam int    CALM_ITEMS   = 150;
    localparam int    CYCLE_LIMIT  = 400000;
    localparam data_t DATA_MIN     = data_t'(32'h8000_0000);
    localparam data_t DATA_MAX     = data_t'(32'h7fff_ffff);
    // Operation codes the block treats as no-ops
    localparam kind_t KIND_SPARE   = KIND_REPLACE + kind_t'(1);
    localparam kind_t KIND_LAST    = '1;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

    typedef struct {
        status_t status;
        data_t   popped;
        count_t  count;
    } deque_result_t;

    // Mirror of the deque contents plus the queue of results still owed
    class deque_board;
        data_t         slots[DEPTH];
        int            front;
        int            held;
        deque_result_t owed[$];
        int            mismatches;
        int            checked;
        int            n_full;
        int            n_empty;
        int            n_hit;
        int            n_miss;

        function new();
            front      = 0;
            held       = 0;
            mismatches = 0;
            checked    = 0;
            n_full     = 0;
            n_empty    = 0;
            n_hit      = 0;
            n_miss     = 0;
        endfunction

        // Apply an accepted request to the mirror and queue its result
        function void note_request(kind_t kind, data_t value, data_t new_value);
            deque_result_t res;
            int            slot;
            res.status = ST_OK;
            res.popped = '0;
            case (kind)
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                begin
                    if (held >= DEPTH) begin
                        res.status = ST_FULL;
                        n_full++;
                    end else begin
                        if (kind == KIND_PUSH_FRONT) begin
                            front = (front + DEPTH - 1) % DEPTH;
                            slots[front] = value;
                        end else begin
                            slots[(front + held) % DEPTH] = value;
                        end
                        held++;
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK:
                begin
                    if (held == 0) begin
                        res.status = ST_EMPTY;
                        n_empty++;
                    end else if (kind == KIND_POP_FRONT) begin
                        res.popped = slots[front];
                        front = (front + 1) % DEPTH;
                        held--;
                    end else begin
                        res.popped = slots[(front + held - 1) % DEPTH];
                        held--;
                    end
                end
                KIND_REPLACE:
                begin
                    res.status = ST_NOT_FOUND;
                    for (int i = 0; i < held; i++) begin
                        slot = (front + i) % DEPTH;
                        if (slots[slot] == value) begin
                            slots[slot] = new_value;
                            res.status  = ST_OK;
                            break;
                        end
                    end
                    if (res.status == ST_OK)
                        n_hit++;
                    else
                        n_miss++;
                end
                default:
                begin
                end
            endcase
            res.count = count_t'(held);
            owed.push_back(res);
        endfunction

        // Compare one delivered result with the oldest one owed
        function void check_result(status_t status, data_t popped, count_t count);
            deque_result_t exp;
            if (owed.size() == 0) begin
                $error("result with nothing owed: status %0d popped %0d count %0d",
                       status, popped, count);
                mismatches++;
                return;
            end
            exp = owed.pop_front();
            checked++;
            if (status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, status);
                mismatches++;
            end
            if (popped !== exp.popped) begin
                $error("popped_value: expected %0d, got %0d", exp.popped, popped);
                mismatches++;
            end
            if (count !== exp.count) begin
                $error("entry_count: expected %0d, got %0d", exp.count, count);
                mismatches++;
            end
        endfunction

        // Return one of the values currently held, for searches that hit
        function data_t held_value();
            return slots[(front + $urandom_range(0, held - 1)) % DEPTH];
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    int         idle_odds;
    int         cycle_count = 0;
    deque_board board = new();

    dqsr_req_if req_ch ();
    dqsr_rsp_if rsp_ch ();

    deque_with_search_replace #(
        .CAPACITY   (DEPTH),
        .VALUE_BITS (WIDTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(PERIOD / 2) clk = ~clk;

    // Count cycles for the watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Check every result taken from the block
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_result(rsp_ch.status, rsp_ch.popped_value, rsp_ch.entry_count);
    end

    // Stall the result side in short bursts
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Present one request, with an optional gap first, and hold it until taken
    task automatic send_request(kind_t kind, data_t value, data_t new_value);
        int gap;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            gap = $urandom_range(1, 4);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= kind;
        req_ch.value     <= value;
        req_ch.new_value <= new_value;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        board.note_request(kind, value, new_value);
    endtask

    // Favour extremes and a handful of small values so duplicates are common
    function automatic data_t pick_value();
        case ($urandom_range(0, 9))
            0:       return DATA_MIN;
            1:       return DATA_MAX;
            2, 3, 4: return data_t'($urandom_range(0, 6)) - data_t'(3);
            default: return data_t'($urandom());
        endcase
    endfunction

    function automatic kind_t pick_kind(traffic_mode_t mode);
        int roll;
        int push_share;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  push_share = 70;
            MODE_DRAIN: push_share = 12;
            default:    push_share = 41;
        endcase
        if (roll < 3)
            return kind_t'($urandom_range(KIND_SPARE, KIND_LAST));
        if (roll < 18)
            return KIND_REPLACE;
        if (roll < 18 + push_share)
            return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
    endfunction

    initial
    begin
        traffic_mode_t mode;
        kind_t         kind;
        data_t         value;
        int            sent;
        int            run_len;

        rst_n            = 1'b0;
        idle_odds        = 0;
        req_ch.valid     = 1'b0;
        req_ch.kind      = KIND_PUSH_BACK;
        req_ch.value     = '0;
        req_ch.new_value = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Refusals and no-ops on an empty deque
        send_request(KIND_POP_FRONT, '0, '0);
        send_request(KIND_POP_BACK, '0, '0);
        send_request(KIND_REPLACE, '0, DATA_MAX);
        send_request(KIND_SPARE, DATA_MAX, DATA_MIN);
        send_request(KIND_LAST, DATA_MIN, DATA_MAX);

        // Extremes at both ends: deque becomes 0, MIN, MAX, -1
        send_request(KIND_PUSH_BACK, DATA_MAX, '0);
        send_request(KIND_PUSH_FRONT, DATA_MIN, '0);
        send_request(KIND_PUSH_BACK, -1, '0);
        send_request(KIND_PUSH_FRONT, '0, '0);

        // Match at the back, then only the first of two equal entries, then a miss and a no-op
        send_request(KIND_REPLACE, -1, DATA_MIN);
        send_request(KIND_REPLACE, DATA_MIN, 5);
        send_request(KIND_REPLACE, 42, -1);
        send_request(kind_t'(KIND_SPARE + kind_t'(1)), -1, -1);

        // Drain from both ends, last entry leaving alone, then pop when empty
        send_request(KIND_POP_FRONT, '0, '0);
        send_request(KIND_POP_BACK, '0, '0);
        send_request(KIND_POP_BACK, '0, '0);
        send_request(KIND_POP_FRONT, '0, '0);
        send_request(KIND_POP_BACK, '0, '0);

        // Random runs that fill, drain or mix, with idling varied per run
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       mode = MODE_FILL;
                1:       mode = MODE_DRAIN;
                default: mode = MODE_MIX;
            endcase
            run_len = $urandom_range(8, 40);
            if (sent >= RANDOM_ITEMS - CALM_ITEMS)
                idle_odds = 0;
            else
                case ($urandom_range(0, 2))
                    0:       idle_odds = 0;
                    1:       idle_odds = 3;
                    default: idle_odds = 6;
                endcase
            repeat (run_len)
            begin
                kind = pick_kind(mode);
                if (kind == KIND_REPLACE && board.held > 0 && $urandom_range(0, 9) < 7)
                    value = board.held_value();
                else
                    value = pick_value();
                send_request(kind, value, pick_value());
                sent++;
            end
        end
        req_ch.valid <= 1'b0;

        // Let the last results drain, then watch for strays
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        $display("Checked %0d results over %0d random and directed requests.",
                 board.checked, sent + 18);
        $display("Refusals: %0d full, %0d empty; replaces: %0d matched, %0d not found.",
                 board.n_full, board.n_empty, board.n_hit, board.n_miss);
        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dqsr_pkg.sv
hw/rtl/dqsr_ifs.sv
hw/rtl/deque_with_search_replace.sv
dv/deque_with_search_replace_test.sv
